### src/float64_integral_fraction_split_macros.svh
// Assertion macros for the binary64 integral/fraction split checker.
`ifndef FLOAT64_INTEGRAL_FRACTION_SPLIT_MACROS_SVH
`define FLOAT64_INTEGRAL_FRACTION_SPLIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FIFS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define FIFS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/fifs_pkg.sv
// Package for the binary64 integral/fraction split: constants and split result type.
package fifs_pkg;

  localparam int unsigned MantW = 52;
  localparam int unsigned ExpW  = 11;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [ExpW-1:0] ExpMax  = 11'h7FF;
  localparam logic [63:0] QnanBits = 64'h7FF8000000000000;

  typedef struct packed {
    logic [63:0] integral_bits;
    logic [63:0] frac_bits;
  } split_t;

endpackage

### src/float64_integral_fraction_split.sv
// Top level: binary64 integral/fraction split with a registered stream output.
//
// Channel | Dir | tdata fields (low bit up)
// s_axis  | in  | x_bits[63:0]
// m_axis  | out | integral_bits[63:0], frac_bits[127:64]
//
// One transaction per cycle while the output is not stalled; results appear in the cycle after acceptance.
// The split is a single combinational pass into the output register.
// rst (synchronous) clears the output valid flag only.
// A stalled output holds its data; input is taken when the output is free
// or being drained in the same cycle.
module float64_integral_fraction_split
  import fifs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // x_bits[63:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // integral_bits[63:0], frac_bits[127:64]
);

  split_t res;
  split_t out_reg;
  logic   out_valid;

  fifs_core u_core (
    .x_bits (s_axis_tdata),
    .res    (res)
  );

  assign s_axis_tready = !out_valid || m_axis_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      out_reg <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.frac_bits, out_reg.integral_bits};

endmodule

### src/fifs_core.sv
// Combinational split of one binary64 value into integral and fractional parts.
module fifs_core
  import fifs_pkg::*;
(
  input  logic [63:0] x_bits,
  output split_t      res
);

  logic            sign;
  logic [ExpW-1:0] bexp;
  logic [MantW-1:0] mant;
  logic [ExpW-1:0] e_full;
  logic [5:0]      e;
  logic [MantW-1:0] fmask;
  logic [MantW-1:0] fbits;
  logic [5:0]      lz;
  logic [5:0]      p;
  logic [MantW-1:0] fmant;
  logic [ExpW-1:0] fexp;
  logic            found;

  assign sign   = x_bits[63];
  assign bexp   = x_bits[62:52];
  assign mant   = x_bits[51:0];
  assign e_full = bexp - ExpBias;
  assign e      = e_full[5:0];
  // bits below the binary point; hidden bit never falls there when e <= 51
  assign fmask  = {MantW{1'b1}} >> e;
  assign fbits  = mant & fmask;

  // leading-one search over the fraction field
  always_comb begin
    lz = 6'd0;
    found = 1'b0;
    for (int i = MantW - 1; i >= 0; i--) begin
      if (!found && fbits[i]) begin
        found = 1'b1;
        lz = 6'(MantW - 1 - i);
      end
    end
  end

  assign p     = 6'(MantW - 1) - lz;
  assign fmant = fbits << (lz + 6'd1);
  // exponent of the fraction: p + e - 52 + bias
  assign fexp  = ExpBias + 11'(p) + 11'(e) - 11'(MantW);

  // case selection
  always_comb begin
    res.integral_bits = x_bits;
    res.frac_bits     = {sign, 63'd0};
    if (bexp == ExpMax) begin
      if (mant != '0) begin
        res.integral_bits = QnanBits;
        res.frac_bits     = QnanBits;
      end
    end else if (x_bits[62:0] == '0) begin
      res.frac_bits = x_bits;
    end else if (bexp < ExpBias) begin
      res.integral_bits = {sign, 63'd0};
      res.frac_bits     = x_bits;
    end else if (e_full >= 11'(MantW)) begin
      res.frac_bits = {sign, 63'd0};
    end else if (fbits != '0) begin
      res.integral_bits = {x_bits[63:52], mant & ~fmask};
      res.frac_bits     = {sign, fexp, fmant};
    end
  end

endmodule

### src/fifs_checker.sv
// Port-level checker for the binary64 integral/fraction split, with bind.
`include "float64_integral_fraction_split_macros.svh"
module fifs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  `FIFS_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
  `FIFS_ASSERT_IMP(a_ready_free, clk, rst, !m_axis_tvalid, s_axis_tready, "not ready while output empty")
  `FIFS_ASSERT_NXT(a_accept_out, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted transaction produced no result")
  `FIFS_ASSERT_IMP(a_sign_match, clk, rst, m_axis_tvalid && m_axis_tdata[62:52] != 11'h7FF, m_axis_tdata[63] == m_axis_tdata[127], "parts disagree in sign")

endmodule

bind float64_integral_fraction_split fifs_checker u_fifs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
